// ----- src/multi_segment_linear_envelope_unit_macros.svh -----
// Assertion macros for the envelope unit.
`ifndef MULTI_SEGMENT_LINEAR_ENVELOPE_UNIT_MACROS_SVH
`define MULTI_SEGMENT_LINEAR_ENVELOPE_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MSLE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("envelope unit: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define MSLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("envelope unit: next-cycle check failed");

`endif

// ----- src/msle_pkg.sv -----
// Types, constants and codes shared by the envelope unit modules.
`default_nettype none
package msle_pkg;

	localparam int MAX_SEGMENTS = 16;
	localparam int SEG_W        = $clog2(MAX_SEGMENTS);
	localparam int COUNT_W      = $clog2(MAX_SEGMENTS + 1);
	localparam int LEVEL_W      = 24;
	localparam int DUR_W        = 24;
	localparam int FRAC_EXTRA   = 15;
	localparam int ACC_W        = 40;
	localparam int DIV_STEPS    = ACC_W;
	localparam int DIV_CNT_W    = $clog2(DIV_STEPS);
	localparam int QUEUE_DEPTH  = 2;
	localparam int QUEUE_AW     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 24;

	localparam logic [1:0] KIND_TICK  = 2'd0;
	localparam logic [1:0] KIND_GATE  = 2'd1;
	localparam logic [1:0] KIND_WRITE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_LEVEL  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_COUNT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN_ENABLE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN_INDEX  = 2'd3;

	typedef enum logic [1:0] {
		OP_TICK,
		OP_GATE,
		OP_WRITE,
		OP_NONE
	} op_t;

	typedef struct packed {
		logic [1:0]                kind;
		logic                      gate;
		logic [3:0]                seg_index;
		logic signed [LEVEL_W-1:0] seg_target;
		logic [DUR_W-1:0]          seg_duration;
	} in_item_t;

	typedef struct packed {
		logic signed [LEVEL_W-1:0] level;
		logic                      is_active;
		logic                      is_holding;
		logic [3:0]                segment_now;
	} out_item_t;

	typedef struct packed {
		op_t                       op;
		logic                      gate;
		logic [SEG_W-1:0]          index;
		logic signed [LEVEL_W-1:0] target;
		logic [DUR_W-1:0]          duration;
	} q_entry_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

	typedef struct packed {
		logic signed [LEVEL_W-1:0] target;
		logic [DUR_W-1:0]          duration;
	} seg_word_t;

	typedef struct packed {
		logic               start;
		logic [ACC_W-1:0]   dividend;
		logic [DUR_W-1:0]   divisor;
	} div_req_t;

	typedef struct packed {
		logic               busy;
		logic               done;
		logic [ACC_W-1:0]   quotient;
	} div_rsp_t;

endpackage
`default_nettype wire

// ----- src/msle_ram.sv -----
// Generic RAM: one write port, one read port with registered read data.
`default_nettype none
module msle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ----- src/msle_div.sv -----
// Iterative restoring divider, one quotient bit a cycle, rounds the quotient up.
`default_nettype none
module msle_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire msle_pkg::div_req_t req,
	output msle_pkg::div_rsp_t     rsp
);

	typedef enum logic [1:0] {
		DV_IDLE,
		DV_RUN,
		DV_ROUND
	} dv_state_t;

	dv_state_t                          state_q;
	logic [msle_pkg::DIV_CNT_W-1:0]     cnt_q;
	logic [msle_pkg::ACC_W-1:0]         quot_q;
	logic [msle_pkg::DUR_W-1:0]         rem_q;
	logic [msle_pkg::DUR_W-1:0]         dsr_q;
	logic                               done_q;

	logic [msle_pkg::DUR_W:0]           rem_sh;
	logic [msle_pkg::DUR_W:0]           rem_sub;
	logic                               ge;

	always_comb begin
		rem_sh  = {rem_q, quot_q[msle_pkg::ACC_W-1]};
		rem_sub = rem_sh - {1'b0, dsr_q};
		ge      = rem_sh >= {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DV_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				DV_IDLE: begin
					if (req.start) begin
						quot_q  <= req.dividend;
						dsr_q   <= req.divisor;
						rem_q   <= '0;
						cnt_q   <= '0;
						state_q <= DV_RUN;
					end
				end
				DV_RUN: begin
					rem_q  <= ge ? rem_sub[msle_pkg::DUR_W-1:0] : rem_sh[msle_pkg::DUR_W-1:0];
					quot_q <= {quot_q[msle_pkg::ACC_W-2:0], ge};
					if (cnt_q == msle_pkg::DIV_CNT_W'(msle_pkg::DIV_STEPS - 1)) begin
						state_q <= DV_ROUND;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				DV_ROUND: begin
					quot_q  <= quot_q + msle_pkg::ACC_W'(rem_q != '0);
					done_q  <= 1'b1;
					state_q <= DV_IDLE;
				end
				default: begin
					state_q <= DV_IDLE;
				end
			endcase
		end
	end

	assign rsp.busy     = state_q != DV_IDLE;
	assign rsp.done     = done_q;
	assign rsp.quotient = quot_q;

endmodule
`default_nettype wire

// ----- src/msle_queue.sv -----
// Short item queue between the front and the back.
`default_nettype none
module msle_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire msle_pkg::q_entry_t  push_entry,
	input  wire logic                pop,
	output msle_pkg::q_entry_t       head,
	output msle_pkg::q_status_t      status
);

	msle_pkg::q_entry_t                entries_q [msle_pkg::QUEUE_DEPTH];
	logic [msle_pkg::QUEUE_AW-1:0]     wr_ptr_q;
	logic [msle_pkg::QUEUE_AW-1:0]     rd_ptr_q;
	logic [msle_pkg::QUEUE_CNT_W-1:0]  count_q;

	function automatic logic [msle_pkg::QUEUE_AW-1:0] ptr_next(
		input logic [msle_pkg::QUEUE_AW-1:0] p
	);
		if (p == msle_pkg::QUEUE_AW'(msle_pkg::QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign head         = entries_q[rd_ptr_q];
	assign status.empty = count_q == '0;
	assign status.full  = count_q == msle_pkg::QUEUE_CNT_W'(msle_pkg::QUEUE_DEPTH);

endmodule
`default_nettype wire

// ----- src/msle_front.sv -----
// Front: accepts input items, classifies them and pushes them into the queue.
`default_nettype none
module msle_front (
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire msle_pkg::in_item_t   in_item,
	input  wire msle_pkg::q_status_t  q_status,
	output logic                      push,
	output msle_pkg::q_entry_t        push_entry
);

	msle_pkg::op_t op;

	always_comb begin
		case (in_item.kind)
			msle_pkg::KIND_TICK:  op = msle_pkg::OP_TICK;
			msle_pkg::KIND_GATE:  op = msle_pkg::OP_GATE;
			msle_pkg::KIND_WRITE: begin
				// drop writes beyond the table
				if (32'(in_item.seg_index) < msle_pkg::MAX_SEGMENTS) begin
					op = msle_pkg::OP_WRITE;
				end else begin
					op = msle_pkg::OP_NONE;
				end
			end
			default: op = msle_pkg::OP_NONE;
		endcase
	end

	assign in_stall            = q_status.full;
	assign push                = in_valid && !q_status.full;
	assign push_entry.op       = op;
	assign push_entry.gate     = in_item.gate;
	assign push_entry.index    = msle_pkg::SEG_W'(in_item.seg_index);
	assign push_entry.target   = in_item.seg_target;
	assign push_entry.duration = in_item.seg_duration;

endmodule
`default_nettype wire

// ----- src/msle_back.sv -----
// Back: configuration, envelope state, segment entry and result register.
`default_nettype none
module msle_back (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [msle_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [msle_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wire msle_pkg::q_entry_t                 q_head,
	input  wire msle_pkg::q_status_t                q_status,
	output logic                                    q_pop,
	output logic                                    ram_we,
	output logic [msle_pkg::SEG_W-1:0]              ram_waddr,
	output msle_pkg::seg_word_t                     ram_wdata,
	output logic                                    ram_re,
	output logic [msle_pkg::SEG_W-1:0]              ram_raddr,
	input  wire msle_pkg::seg_word_t                ram_rdata,
	output msle_pkg::div_req_t                      div_req,
	input  wire msle_pkg::div_rsp_t                 div_rsp,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output msle_pkg::out_item_t                     out_item
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DIV,
		ST_EMIT
	} bk_state_t;

	localparam int EXT_W = msle_pkg::ACC_W - msle_pkg::LEVEL_W - msle_pkg::FRAC_EXTRA;

	bk_state_t                                 state_q;
	logic signed [msle_pkg::LEVEL_W-1:0]       init_lvl_q;
	logic [msle_pkg::COUNT_W-1:0]              seg_count_q;
	logic                                      sus_en_q;
	logic [msle_pkg::SEG_W-1:0]                sus_idx_q;
	logic signed [msle_pkg::ACC_W-1:0]         level_acc_q;
	logic signed [msle_pkg::ACC_W-1:0]         slope_q;
	logic [msle_pkg::SEG_W-1:0]                cursor_q;
	logic                                      running_q;
	logic                                      holding_q;
	logic                                      gate_last_q;
	logic signed [msle_pkg::LEVEL_W-1:0]       cur_tgt_q;
	logic signed [msle_pkg::LEVEL_W-1:0]       prev_q;
	logic [msle_pkg::SEG_W-1:0]                next_idx_q;
	logic                                      neg_q;
	logic                                      out_valid_q;
	msle_pkg::out_item_t                       out_q;

	logic signed [msle_pkg::ACC_W-1:0]         tgt_w;
	logic signed [msle_pkg::ACC_W-1:0]         init_w;
	logic signed [msle_pkg::ACC_W:0]           rem_w;
	logic signed [msle_pkg::ACC_W:0]           slope_x;
	logic                                      arrived;
	logic [msle_pkg::COUNT_W-1:0]              eff_cnt;
	logic                                      is_last;
	logic                                      sus_ok;
	logic [msle_pkg::SEG_W-1:0]                cursor_inc;
	logic signed [msle_pkg::LEVEL_W:0]         diff;
	logic [msle_pkg::LEVEL_W:0]                diff_neg;
	logic [msle_pkg::LEVEL_W-1:0]              mag;
	logic [msle_pkg::DUR_W-1:0]                dur_eff;
	logic                                      out_free;

	always_comb begin
		tgt_w   = {{EXT_W{cur_tgt_q[msle_pkg::LEVEL_W-1]}}, cur_tgt_q,
			{msle_pkg::FRAC_EXTRA{1'b0}}};
		init_w  = {{EXT_W{init_lvl_q[msle_pkg::LEVEL_W-1]}}, init_lvl_q,
			{msle_pkg::FRAC_EXTRA{1'b0}}};
		rem_w   = {tgt_w[msle_pkg::ACC_W-1], tgt_w}
			- {level_acc_q[msle_pkg::ACC_W-1], level_acc_q};
		slope_x = {slope_q[msle_pkg::ACC_W-1], slope_q};
		if (slope_q == '0) begin
			arrived = 1'b1;
		end else if (slope_q[msle_pkg::ACC_W-1]) begin
			arrived = rem_w >= slope_x;
		end else begin
			arrived = rem_w <= slope_x;
		end
		eff_cnt = (seg_count_q > msle_pkg::COUNT_W'(msle_pkg::MAX_SEGMENTS))
			? msle_pkg::COUNT_W'(msle_pkg::MAX_SEGMENTS) : seg_count_q;
		cursor_inc = cursor_q + 1'b1;
		is_last = (msle_pkg::COUNT_W'(cursor_q) + 1'b1) >= eff_cnt;
		sus_ok  = sus_en_q && (msle_pkg::COUNT_W'(sus_idx_q) < eff_cnt);

		diff     = {ram_rdata.target[msle_pkg::LEVEL_W-1], ram_rdata.target}
			- {prev_q[msle_pkg::LEVEL_W-1], prev_q};
		diff_neg = '0 - diff;
		mag      = diff[msle_pkg::LEVEL_W] ? diff_neg[msle_pkg::LEVEL_W-1:0]
			: diff[msle_pkg::LEVEL_W-1:0];
		dur_eff  = (ram_rdata.duration == '0) ? msle_pkg::DUR_W'(1) : ram_rdata.duration;

		out_free = !out_valid_q || !out_stall;
	end

	assign q_pop     = (state_q == ST_IDLE) && !q_status.empty;
	assign ram_we    = q_pop && (q_head.op == msle_pkg::OP_WRITE);
	assign ram_waddr = q_head.index;
	assign ram_wdata = '{target: q_head.target, duration: q_head.duration};
	assign ram_re    = q_pop;
	assign ram_raddr = (q_head.op == msle_pkg::OP_GATE) ? '0 : cursor_inc;

	assign div_req.start    = state_q == ST_LOAD;
	assign div_req.dividend = msle_pkg::ACC_W'({mag, {msle_pkg::FRAC_EXTRA{1'b0}}});
	assign div_req.divisor  = dur_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			init_lvl_q  <= '0;
			seg_count_q <= '0;
			sus_en_q    <= 1'b0;
			sus_idx_q   <= '0;
			level_acc_q <= '0;
			slope_q     <= '0;
			cursor_q    <= '0;
			running_q   <= 1'b0;
			holding_q   <= 1'b0;
			gate_last_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					msle_pkg::CFG_INITIAL_LEVEL:  init_lvl_q  <= cfg_data[msle_pkg::LEVEL_W-1:0];
					msle_pkg::CFG_SEGMENT_COUNT:  seg_count_q <= cfg_data[msle_pkg::COUNT_W-1:0];
					msle_pkg::CFG_SUSTAIN_ENABLE: sus_en_q    <= cfg_data[0];
					msle_pkg::CFG_SUSTAIN_INDEX:  sus_idx_q   <= cfg_data[msle_pkg::SEG_W-1:0];
					default: ;
				endcase
			end

			if (state_q == ST_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (!q_status.empty) begin
						case (q_head.op)
							msle_pkg::OP_TICK: begin
								if (!running_q) begin
									level_acc_q <= '0;
									state_q     <= ST_EMIT;
								end else if (holding_q) begin
									state_q <= ST_EMIT;
								end else if (!arrived) begin
									level_acc_q <= level_acc_q + slope_q;
									state_q     <= ST_EMIT;
								end else if (sus_ok && cursor_q == sus_idx_q && gate_last_q) begin
									level_acc_q <= tgt_w;
									holding_q   <= 1'b1;
									state_q     <= ST_EMIT;
								end else if (is_last) begin
									running_q   <= 1'b0;
									holding_q   <= 1'b0;
									cursor_q    <= '0;
									slope_q     <= '0;
									level_acc_q <= '0;
									state_q     <= ST_EMIT;
								end else begin
									level_acc_q <= tgt_w;
									prev_q      <= cur_tgt_q;
									next_idx_q  <= cursor_inc;
									state_q     <= ST_LOAD;
								end
							end
							msle_pkg::OP_GATE: begin
								gate_last_q <= q_head.gate;
								if (q_head.gate && !gate_last_q && eff_cnt != '0) begin
									running_q   <= 1'b1;
									holding_q   <= 1'b0;
									level_acc_q <= init_w;
									prev_q      <= init_lvl_q;
									next_idx_q  <= '0;
									state_q     <= ST_LOAD;
								end else begin
									if (!q_head.gate && gate_last_q) begin
										holding_q <= 1'b0;
									end
									state_q <= ST_EMIT;
								end
							end
							msle_pkg::OP_WRITE: begin
								// keep the live target in step with the table
								if (q_head.index == cursor_q) begin
									cur_tgt_q <= q_head.target;
								end
								state_q <= ST_EMIT;
							end
							default: begin
								state_q <= ST_EMIT;
							end
						endcase
					end
				end
				ST_LOAD: begin
					cur_tgt_q <= ram_rdata.target;
					cursor_q  <= next_idx_q;
					neg_q     <= diff[msle_pkg::LEVEL_W];
					state_q   <= ST_DIV;
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						slope_q <= neg_q ? ('0 - div_rsp.quotient) : div_rsp.quotient;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_q.level       <= running_q
							? level_acc_q[msle_pkg::FRAC_EXTRA +: msle_pkg::LEVEL_W] : '0;
						out_q.is_active   <= running_q;
						out_q.is_holding  <= holding_q;
						out_q.segment_now <= running_q ? 4'(cursor_q) : 4'd0;
						state_q           <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule
`default_nettype wire

// ----- src/multi_segment_linear_envelope_unit.sv -----
// An accepted item passes the queue and the back's idle and emit states; its result is
// registered on leaving emit, which an output stall holds. A tick or rising gate that
// enters a segment also passes the load and slope-division states. The back takes one item
// at a time; the 40-step divider slows segment entry; the two-entry queue absorbs bursts.
// Reset: asynchronous, active low; clears configuration, envelope state and queue.
// Segment table contents are undefined until written.
`default_nettype none
`include "multi_segment_linear_envelope_unit_macros.svh"
module multi_segment_linear_envelope_unit (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [msle_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [msle_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire msle_pkg::in_item_t                 in_item,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output msle_pkg::out_item_t                     out_item
);

	msle_pkg::q_status_t            q_status;
	msle_pkg::q_entry_t             q_push_entry;
	msle_pkg::q_entry_t             q_head;
	logic                           q_push;
	logic                           q_pop;
	logic                           ram_we;
	logic [msle_pkg::SEG_W-1:0]     ram_waddr;
	msle_pkg::seg_word_t            ram_wdata;
	logic                           ram_re;
	logic [msle_pkg::SEG_W-1:0]     ram_raddr;
	msle_pkg::seg_word_t            ram_rdata;
	msle_pkg::div_req_t             div_req;
	msle_pkg::div_rsp_t             div_rsp;

	msle_front u_front (
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_item    (in_item),
		.q_status   (q_status),
		.push       (q_push),
		.push_entry (q_push_entry)
	);

	msle_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_push_entry),
		.pop        (q_pop),
		.head       (q_head),
		.status     (q_status)
	);

	msle_ram #(
		.WIDTH ($bits(msle_pkg::seg_word_t)),
		.DEPTH (msle_pkg::MAX_SEGMENTS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	msle_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	msle_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_head    (q_head),
		.q_status  (q_status),
		.q_pop     (q_pop),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.div_req   (div_req),
		.div_rsp   (div_rsp),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

	`MSLE_ASSERT_NEXT(a_push_lands, clk, arst_n, q_push, !q_status.empty)
	`MSLE_ASSERT_IMPL(a_pop_nonempty, clk, arst_n, q_pop, !q_status.empty)
	`MSLE_ASSERT_IMPL(a_div_start_idle, clk, arst_n, div_req.start, !div_rsp.busy)

endmodule
`default_nettype wire
